### rtl/kbt_pkg.sv
// kbt_pkg: shared types and constants of the k-mer binary trie unit
// used by kbt_front, kbt_back and the top level, depends on nothing

package kbt_pkg;

  // longest k-mer the trie walks
  localparam int MAX_KMER = 32;

  // reset value of the k-mer length register
  localparam logic [5:0] KMER_RESET = 6'd8;

  // ascii codes of the valid bases
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  // two-bit base codes
  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } kbt_status_t;

  // one input character
  typedef struct packed {
    logic       mode;
    logic [7:0] base_char;
    logic       last;
  } kbt_in_t;

  // one result
  typedef struct packed {
    logic        found;
    logic [1:0]  status;
    logic [11:0] node_count;
  } kbt_out_t;

  // classified character as handed from front to back
  typedef struct packed {
    logic       mode;
    logic       valid;
    logic [1:0] code;
    logic       last;
  } kbt_cmd_t;

endpackage

### rtl/kbt_fifo.sv
// kbt_fifo: small first-word-fall-through queue of flip-flops
// depends on nothing; DEPTH must be a power of two

module kbt_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + (PW+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (PW+1)'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

### rtl/kbt_front.sv
// kbt_front: accepts characters, decodes the base and queues them for the back end
// depends on kbt_pkg and kbt_fifo

module kbt_front
  import kbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  kbt_in_t  in_data,
  input  logic     cmd_pop,
  output logic     cmd_empty,
  output kbt_cmd_t cmd
);

  localparam int CMD_W   = $bits(kbt_cmd_t);
  localparam int CMD_DEP = 4;

  kbt_cmd_t         cls;
  logic [CMD_W-1:0] q_data;

  // base decode
  always_comb begin
    cls.mode  = in_data.mode;
    cls.last  = in_data.last;
    cls.valid = 1'b1;
    case (in_data.base_char)
      CHAR_A:  cls.code = CODE_A;
      CHAR_C:  cls.code = CODE_C;
      CHAR_G:  cls.code = CODE_G;
      CHAR_T:  cls.code = CODE_T;
      default: begin
        cls.code  = CODE_A;
        cls.valid = 1'b0;
      end
    endcase
  end

  // character queue between front and back
  kbt_fifo #(
    .W     (CMD_W),
    .DEPTH (CMD_DEP)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (cls),
    .full    (in_full),
    .pop     (cmd_pop),
    .rd_data (q_data),
    .empty   (cmd_empty)
  );

  assign cmd = kbt_cmd_t'(q_data);

endmodule

### rtl/kbt_back.sv
// kbt_back: trie walker; node pool memories, root pointers and the per-string sequencer
// depends on kbt_pkg

module kbt_back
  import kbt_pkg::*;
#(
  parameter int NODE_POOL = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [5:0]                   cfg_wr_data,
  input  logic                         cmd_empty,
  input  kbt_cmd_t                     cmd,
  output logic                         cmd_pop,
  input  logic                         res_full,
  output logic                         res_push,
  output kbt_out_t                     res_data,
  output logic [$clog2(NODE_POOL)-1:0] alloc_cnt
);

  localparam int AW = $clog2(NODE_POOL);
  localparam logic [AW-1:0] POOL_LAST = AW'(NODE_POOL - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_LINK,
    S_END,
    S_FIN
  } seq_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2,
    ST_DONE = 2'd3
  } str_t;

  // node pool
  logic [AW-1:0] left_mem  [NODE_POOL];
  logic [AW-1:0] right_mem [NODE_POOL];
  logic          end_mem   [NODE_POOL];
  logic [AW-1:0] rd_left_q;
  logic [AW-1:0] rd_right_q;
  logic          rd_end_q;

  // sequencer state
  seq_t          state_r,  state_nxt;
  str_t          sst_r,    sst_nxt;
  logic          mode_r,   mode_nxt;
  logic [1:0]    code_r,   code_nxt;
  logic          last_r,   last_nxt;
  logic          level_r,  level_nxt;
  logic          hit_r,    hit_nxt;
  logic [5:0]    pos_r,    pos_nxt;
  logic [AW-1:0] cursor_r, cursor_nxt;
  logic [AW-1:0] new_r,    new_nxt;
  logic [AW-1:0] alloc_r,  alloc_nxt;
  logic [AW-1:0] rootl_r,  rootl_nxt;
  logic [AW-1:0] rootr_r,  rootr_nxt;
  logic [5:0]    kmer_r;

  // memory ports
  logic [AW-1:0] rd_addr;
  logic          wl_en, wr_en, we_en;
  logic [AW-1:0] wl_addr, wr_addr, we_addr;
  logic [AW-1:0] wl_data, wr_data;
  logic          we_data;

  // walker helpers
  logic          bit_sel;
  logic [AW-1:0] child;
  logic          adv;
  logic [AW-1:0] adv_node;
  logic [5:0]    eff_k;
  logic          pos_hit;
  logic          str_start;

  // effective k: zero acts as one, clamp at the longest k-mer
  always_comb begin
    if (kmer_r == 6'd0) eff_k = 6'd1;
    else if ({1'b0, kmer_r} > 7'(MAX_KMER)) eff_k = 6'(MAX_KMER);
    else eff_k = kmer_r;
  end

  assign pos_hit   = (({1'b0, pos_r} + 7'd1) >= {1'b0, eff_k});
  assign bit_sel   = level_r ? code_r[0] : code_r[1];
  assign child     = (cursor_r == '0) ? (bit_sel ? rootr_r : rootl_r)
                                      : (bit_sel ? rd_right_q : rd_left_q);
  assign str_start = (sst_r == ST_RUN) && (pos_r == 6'd0);
  assign alloc_cnt = alloc_r;

  // next-state logic of the walker
  always_comb begin
    state_nxt  = state_r;
    sst_nxt    = sst_r;
    mode_nxt   = mode_r;
    code_nxt   = code_r;
    last_nxt   = last_r;
    level_nxt  = level_r;
    hit_nxt    = hit_r;
    pos_nxt    = pos_r;
    cursor_nxt = cursor_r;
    new_nxt    = new_r;
    alloc_nxt  = alloc_r;
    rootl_nxt  = rootl_r;
    rootr_nxt  = rootr_r;
    rd_addr    = cursor_r;
    wl_en      = 1'b0;
    wr_en      = 1'b0;
    we_en      = 1'b0;
    wl_addr    = cursor_r;
    wr_addr    = cursor_r;
    we_addr    = cursor_r;
    wl_data    = '0;
    wr_data    = '0;
    we_data    = 1'b0;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_data   = '0;
    adv        = 1'b0;
    adv_node   = child;

    case (state_r)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop   = 1'b1;
          code_nxt  = cmd.code;
          last_nxt  = cmd.last;
          level_nxt = 1'b0;
          if (str_start) begin
            mode_nxt   = cmd.mode;
            cursor_nxt = '0;
            hit_nxt    = 1'b0;
          end
          if (sst_r == ST_RUN) begin
            if (!cmd.valid) begin
              sst_nxt   = ST_BAD;
              state_nxt = S_FIN;
            end else begin
              rd_addr   = str_start ? '0 : cursor_r;
              state_nxt = S_CHK;
            end
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_CHK: begin
        if (child != '0) begin
          adv      = 1'b1;
          adv_node = child;
        end else if (mode_r) begin
          hit_nxt   = 1'b0;
          sst_nxt   = ST_DONE;
          state_nxt = S_FIN;
        end else if (alloc_r >= POOL_LAST) begin
          sst_nxt   = ST_FULL;
          state_nxt = S_FIN;
        end else begin
          // new node, cleared on allocation
          alloc_nxt = alloc_r + AW'(1);
          new_nxt   = alloc_r + AW'(1);
          wl_en     = 1'b1;
          wr_en     = 1'b1;
          we_en     = 1'b1;
          wl_addr   = alloc_r + AW'(1);
          wr_addr   = alloc_r + AW'(1);
          we_addr   = alloc_r + AW'(1);
          state_nxt = S_LINK;
        end
      end

      S_LINK: begin
        // hook the new node under its parent
        if (cursor_r == '0) begin
          if (bit_sel) rootr_nxt = new_r;
          else rootl_nxt = new_r;
        end else if (bit_sel) begin
          wr_en   = 1'b1;
          wr_data = new_r;
        end else begin
          wl_en   = 1'b1;
          wl_data = new_r;
        end
        adv      = 1'b1;
        adv_node = new_r;
      end

      S_END: begin
        hit_nxt   = rd_end_q;
        sst_nxt   = ST_DONE;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (last_r) begin
          res_push            = 1'b1;
          res_data.node_count = 12'(alloc_r);
          case (sst_r)
            ST_DONE: begin
              res_data.status = STAT_OK;
              res_data.found  = mode_r & hit_r;
            end
            ST_FULL: res_data.status = STAT_FULL;
            default: res_data.status = STAT_BAD;
          endcase
          cursor_nxt = '0;
          pos_nxt    = 6'd0;
          sst_nxt    = ST_RUN;
          hit_nxt    = 1'b0;
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // one trie level taken: go on to the low bit or finish the base
    if (adv) begin
      cursor_nxt = adv_node;
      if (!level_r) begin
        level_nxt = 1'b1;
        rd_addr   = adv_node;
        state_nxt = S_CHK;
      end else begin
        pos_nxt   = pos_r + 6'd1;
        state_nxt = S_FIN;
        if (pos_hit) begin
          if (mode_r) begin
            rd_addr   = adv_node;
            state_nxt = S_END;
          end else begin
            we_en   = 1'b1;
            we_addr = adv_node;
            we_data = 1'b1;
            sst_nxt = ST_DONE;
          end
        end
      end
    end
  end

  // sequencer and string registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sst_r    <= ST_RUN;
      mode_r   <= 1'b0;
      hit_r    <= 1'b0;
      level_r  <= 1'b0;
      last_r   <= 1'b0;
      pos_r    <= 6'd0;
      cursor_r <= '0;
      alloc_r  <= '0;
      rootl_r  <= '0;
      rootr_r  <= '0;
      kmer_r   <= KMER_RESET;
    end else begin
      state_r  <= state_nxt;
      sst_r    <= sst_nxt;
      mode_r   <= mode_nxt;
      hit_r    <= hit_nxt;
      level_r  <= level_nxt;
      last_r   <= last_nxt;
      pos_r    <= pos_nxt;
      cursor_r <= cursor_nxt;
      alloc_r  <= alloc_nxt;
      rootl_r  <= rootl_nxt;
      rootr_r  <= rootr_nxt;
      if (cfg_wr_en) kmer_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    new_r  <= new_nxt;
  end

  // node pool: one write and one registered read per array
  always_ff @(posedge clk) begin
    if (wl_en) left_mem[wl_addr] <= wl_data;
    if (wr_en) right_mem[wr_addr] <= wr_data;
    if (we_en) end_mem[we_addr] <= we_data;
    rd_left_q  <= left_mem[rd_addr];
    rd_right_q <= right_mem[rd_addr];
    rd_end_q   <= end_mem[rd_addr];
  end

endmodule

### rtl/kmer_binary_trie_unit.sv
// kmer_binary_trie_unit: top level of the dna k-mer set held in a binary trie
// depends on kbt_pkg, kbt_front, kbt_back and kbt_fifo
//
// Usage
//   Input queue: in_push with in_data (mode, base_char, last); a character is
//   taken when in_push is high and in_full low. Strings arrive one character
//   at a time, the mode of the first character counts, last closes the string.
//   Result queue: out_data (found, status, node_count) is valid while out_empty
//   is low and leaves on out_pop. One result per string, on its last character.
//   cfg_wr_en / cfg_wr_data write k (bases used per string) while idle.
// Timing
//   The back end walks one character at a time: a skipped or invalid character
//   goes from idle straight to the finish step, a base checks its two trie
//   levels in turn, each node allocated adds a link step and a finished search
//   adds the end-mark read, all from the dependent node reads through the
//   registered read port of the node pool. A 4-deep character queue and a
//   2-deep result queue sit on either side, so input keeps flowing while a
//   result waits for pop; the walker pauses when the result queue is full.
// Reset
//   Synchronous, active low: trie empty, k = 8. No clearing pass; a node is
//   cleared when it is allocated.

module kmer_binary_trie_unit
  import kbt_pkg::*;
#(
  parameter int NODE_POOL = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  kbt_in_t    in_data,
  output logic       out_empty,
  input  logic       out_pop,
  output kbt_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  localparam int AW    = $clog2(NODE_POOL);
  localparam int RES_W = $bits(kbt_out_t);

  kbt_cmd_t         cmd;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_push;
  logic             res_full;
  kbt_out_t         res_data;
  logic [RES_W-1:0] res_q;
  logic [AW-1:0]    alloc_cnt;

  // front: decode and queue characters
  kbt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  // back: trie walk over the node pool
  kbt_back #(
    .NODE_POOL (NODE_POOL)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_empty   (cmd_empty),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_data),
    .alloc_cnt   (alloc_cnt)
  );

  // result queue
  kbt_fifo #(
    .W     (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_q),
    .empty   (out_empty)
  );

  assign out_data = kbt_out_t'(res_q);

  // the walker never pushes into a full result queue
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // characters are only taken from a non-empty queue
  a_cmd_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("character popped from empty queue");

  // the node count never goes down outside reset
  a_alloc_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (alloc_cnt >= $past(alloc_cnt)))
    else $error("node count decreased");

  // a result leaves the walker only while it is not taking a character
  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !cmd_pop)
    else $error("result push overlaps character pop");

endmodule
